[hdl/swr_pkg.sv]
// Shared types, wire codes and the checksum fold for the stop-and-wait receiver.
// No dependencies; the other design files of the receiver, apart from swr_if, refer to it by scoped names.
package swr_pkg;

   // Datagram header length in 16-bit words: type, length, checksum, sequence.
   localparam logic [15:0] HEADER_WORDS      = 16'd4;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd10240;
   localparam logic [15:0] SUM_GOOD          = 16'hffff;
   localparam logic [15:0] WORD_COUNT_MAX    = 16'hffff;

   // Packet type codes found in the first header word.
   localparam logic [15:0] PKT_SYN = 16'd1;
   localparam logic [15:0] PKT_FIN = 16'd5;
   localparam logic [15:0] PKT_END = 16'd7;

   typedef enum logic [3:0] {
      REPLY_SYN_ACK = 4'd2,
      REPLY_ACK     = 4'd3,
      REPLY_FIN_ACK = 4'd6,
      REPLY_END_ACK = 4'd8
   } reply_code_type;

   typedef enum logic [1:0] {
      LINK_IDLE   = 2'd0,
      LINK_OPEN   = 2'd1,
      LINK_CLOSED = 2'd2
   } link_type;

   typedef struct packed {
      logic [15:0] word;
      logic        last;
   } word_item_type;

   // Reply fields whose widths do not depend on the file counter width.
   typedef struct packed {
      reply_code_type reply_type;
      logic [15:0]    reply_seq;
      logic [15:0]    reply_checksum;
      logic           accepted;
      logic           deliver_payload;
      logic [15:0]    payload_bytes;
      logic           file_done;
      link_type       link_state;
   } reply_hdr_type;

   // Ones'-complement add with end-around carry.
   function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] w);
      logic [16:0] s;
      s = {1'b0, acc} + {1'b0, w};
      return s[16] ? (s[15:0] + 16'd1) : s[15:0];
   endfunction

endpackage

[hdl/swr_if.sv]
// Channel interfaces of the stop-and-wait receiver: request words, replies, register write.
// Depends on nothing; the reply interface takes the file counter width as a parameter.
interface swr_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] word;
   logic        last;

   modport source (output valid, output word, output last, input ready);
   modport sink   (input valid, input word, input last, output ready);
endinterface

interface swr_rsp_if #(
   parameter int FILE_BYTES_WIDTH = 25
);
   logic                        valid;
   logic                        ready;
   logic [3:0]                  reply_type;
   logic [15:0]                 reply_seq;
   logic [15:0]                 reply_checksum;
   logic                        accepted;
   logic                        deliver_payload;
   logic [15:0]                 payload_bytes;
   logic                        file_done;
   logic [FILE_BYTES_WIDTH-1:0] file_bytes;
   logic [1:0]                  link_state;

   modport source (output valid, output reply_type, output reply_seq, output reply_checksum,
                   output accepted, output deliver_payload, output payload_bytes,
                   output file_done, output file_bytes, output link_state, input ready);
   modport sink   (input valid, input reply_type, input reply_seq, input reply_checksum,
                   input accepted, input deliver_payload, input payload_bytes,
                   input file_done, input file_bytes, input link_state, output ready);
endinterface

interface swr_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] max_payload_bytes;

   modport source (output valid, output max_payload_bytes, input ready);
   modport sink   (input valid, input max_payload_bytes, output ready);
endinterface

[hdl/stop_and_wait_receiver.sv]
// Stop-and-wait receiver: takes datagram words on req_bus and sends one reply header per
// datagram on rsp_bus. Built from swr_in_stage, swr_core and swr_out_stage; uses swr_pkg.
//
// The receiver accepts one 16-bit datagram word per clock cycle, sustained, while rsp_bus
// is ready. Each word is held in the input register and is folded into the checksum as
// it leaves; at the last word of a datagram the core decides the reply, which the reply
// register then holds on rsp_bus until it is taken. The core does one ones'-complement
// add per word that the checksum covers. While a reply waits on rsp_bus the word in the
// input register is held; one more request can still enter if that register is empty,
// and then the input stalls until the reply is taken. The single register
// max_payload_bytes (reset 10240) is written through csr_bus, which is ready whenever
// reset is low, and should be written only while no datagram is in flight. After an
// accepted FIN the link is closed: every later word is taken and dropped, and no reply
// is sent until reset.

module stop_and_wait_receiver #(
   parameter int FILE_BYTES_WIDTH = 25
) (
   input  logic       clock,
   input  logic       reset,
   swr_req_if.sink    req_bus,
   swr_rsp_if.source  rsp_bus,
   swr_csr_if.sink    csr_bus
);

   // Handshake state between the stages.
   logic                        item_valid;
   swr_pkg::word_item_type      item;
   logic                        out_busy;
   logic                        fire;

   // One finished reply travelling from the core to the reply register.
   logic                        res_valid;
   swr_pkg::reply_hdr_type      res_hdr;
   logic [FILE_BYTES_WIDTH-1:0] res_file_bytes;

   // A word is processed in the cycle that it leaves the input register.
   assign fire = item_valid && !out_busy;

   swr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .advance    (!out_busy),
      .item_valid (item_valid),
      .item       (item)
   );

   // The core keeps the datagram and link state and decides the reply at the last word.
   swr_core #(
      .FILE_BYTES_WIDTH (FILE_BYTES_WIDTH)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .csr            (csr_bus),
      .fire           (fire),
      .item           (item),
      .res_valid      (res_valid),
      .res_hdr        (res_hdr),
      .res_file_bytes (res_file_bytes)
   );

   swr_out_stage #(
      .FILE_BYTES_WIDTH (FILE_BYTES_WIDTH)
   ) u_out_stage (
      .clock          (clock),
      .reset          (reset),
      .res_valid      (res_valid),
      .res_hdr        (res_hdr),
      .res_file_bytes (res_file_bytes),
      .busy           (out_busy),
      .rsp            (rsp_bus)
   );

endmodule

[hdl/swr_in_stage.sv]
// Input register of the stop-and-wait receiver: holds one request word for the core.
// Depends on swr_pkg and swr_req_if.
module swr_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   swr_req_if.sink               req,
   input  logic                  advance,
   output logic                  item_valid,
   output swr_pkg::word_item_type item
);

   logic                   valid_ff, valid_in;
   swr_pkg::word_item_type item_ff, item_in;
   logic                   take;

   // The held word leaves whenever the stage behind it can move. Nothing is taken in reset.
   assign req.ready = !reset && (!valid_ff || advance);
   assign take      = req.valid && req.ready;

   always_comb begin
      item_in  = item_ff;
      valid_in = valid_ff;
      if (take) begin
         item_in.word = req.word;
         item_in.last = req.last;
         valid_in     = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hdl/swr_core.sv]
// Datagram state, checksum fold, acceptance check and reply decision of the receiver.
// Depends on swr_pkg and swr_csr_if.
module swr_core #(
   parameter int FILE_BYTES_WIDTH = 25
) (
   input  logic                         clock,
   input  logic                         reset,
   swr_csr_if.sink                      csr,
   input  logic                         fire,
   input  swr_pkg::word_item_type       item,
   output logic                         res_valid,
   output swr_pkg::reply_hdr_type       res_hdr,
   output logic [FILE_BYTES_WIDTH-1:0]  res_file_bytes
);

   localparam int FBW = FILE_BYTES_WIDTH;

   logic [15:0]       max_payload_ff, max_payload_in;
   logic [15:0]       expected_seq_ff, expected_seq_in;
   swr_pkg::link_type link_ff, link_in;
   logic [15:0]       word_count_ff, word_count_in;
   logic [15:0]       pkt_type_ff, pkt_type_in;
   logic [15:0]       pkt_length_ff, pkt_length_in;
   logic [15:0]       pkt_seq_ff, pkt_seq_in;
   logic [15:0]       running_sum_ff, running_sum_in;
   logic [FBW-1:0]    file_total_ff, file_total_in;

   logic [15:0]       idx, type_eff, len_eff, seq_eff, sum_base, addend, sum_new, wc_next;
   logic [16:0]       need;
   logic              first, in_body, pad_last, good, syn_idle;
   logic [FBW:0]      tot_sum;
   logic [FBW-1:0]    tot_sat;
   swr_pkg::reply_code_type rtype;
   logic [15:0]       rseq;

   // Writes are taken whenever the block is out of reset.
   assign csr.ready = !reset;

   always_comb begin
      max_payload_in = max_payload_ff;
      if (csr.valid) begin
         max_payload_in = csr.max_payload_bytes;
      end
   end

   // Header fields of the packet as they stand after this word.
   assign idx      = word_count_ff;
   assign first    = (idx == 16'd0);
   assign type_eff = first ? item.word : pkt_type_ff;
   assign len_eff  = (idx == 16'd1) ? item.word : (first ? 16'd0 : pkt_length_ff);
   assign seq_eff  = (idx == 16'd3) ? item.word : (first ? 16'd0 : pkt_seq_ff);
   assign sum_base = first ? 16'd0 : running_sum_ff;

   // Words covered by the checksum: the header plus the payload rounded up to words.
   assign need     = {1'b0, swr_pkg::HEADER_WORDS} + {1'b0, 16'(({1'b0, len_eff} + 17'd1) >> 1)};
   assign in_body  = ({1'b0, idx} < need);
   assign pad_last = len_eff[0] && ({1'b0, idx} == (need - 17'd1));
   assign addend   = pad_last ? {8'h00, item.word[7:0]} : item.word;
   assign sum_new  = in_body ? swr_pkg::fold_add(sum_base, addend) : sum_base;
   assign wc_next  = (idx == swr_pkg::WORD_COUNT_MAX) ? idx : (idx + 16'd1);

   assign good = (wc_next >= swr_pkg::HEADER_WORDS) && ({1'b0, wc_next} >= need) &&
                 (len_eff <= max_payload_ff) && (sum_new == swr_pkg::SUM_GOOD) &&
                 (seq_eff == expected_seq_ff);
   assign syn_idle = (link_ff == swr_pkg::LINK_IDLE) && (type_eff == swr_pkg::PKT_SYN);

   assign tot_sum = {1'b0, file_total_ff} + {{(FBW + 1 - 16){1'b0}}, len_eff};
   assign tot_sat = tot_sum[FBW] ? {FBW{1'b1}} : tot_sum[FBW-1:0];

   always_comb begin
      expected_seq_in = expected_seq_ff;
      link_in         = link_ff;
      word_count_in   = word_count_ff;
      pkt_type_in     = pkt_type_ff;
      pkt_length_in   = pkt_length_ff;
      pkt_seq_in      = pkt_seq_ff;
      running_sum_in  = running_sum_ff;
      file_total_in   = file_total_ff;
      res_valid       = 1'b0;
      res_file_bytes  = file_total_ff;
      rtype           = swr_pkg::REPLY_ACK;
      rseq            = expected_seq_ff - 16'd1;
      res_hdr.accepted        = good;
      res_hdr.deliver_payload = 1'b0;
      res_hdr.file_done       = 1'b0;
      res_hdr.payload_bytes   = len_eff;

      if (good) begin
         rseq = expected_seq_ff;
         if (syn_idle) begin
            rtype = swr_pkg::REPLY_SYN_ACK;
         end else if (type_eff == swr_pkg::PKT_FIN) begin
            rtype = swr_pkg::REPLY_FIN_ACK;
         end else if (type_eff == swr_pkg::PKT_END) begin
            rtype = swr_pkg::REPLY_END_ACK;
         end
      end else if (syn_idle) begin
         rtype = swr_pkg::REPLY_SYN_ACK;
      end

      if (fire && (link_ff != swr_pkg::LINK_CLOSED)) begin
         pkt_type_in    = type_eff;
         pkt_length_in  = len_eff;
         pkt_seq_in     = seq_eff;
         running_sum_in = sum_new;
         word_count_in  = item.last ? 16'd0 : wc_next;
         if (item.last) begin
            res_valid = 1'b1;
            if (good) begin
               unique case (rtype)
                  swr_pkg::REPLY_SYN_ACK: begin
                     link_in = swr_pkg::LINK_OPEN;
                  end
                  swr_pkg::REPLY_FIN_ACK: begin
                     link_in = swr_pkg::LINK_CLOSED;
                  end
                  swr_pkg::REPLY_END_ACK: begin
                     res_hdr.file_done = 1'b1;
                     file_total_in     = '0;
                  end
                  default: begin
                  end
               endcase
               if ((rtype != swr_pkg::REPLY_END_ACK) && (rtype != swr_pkg::REPLY_FIN_ACK)) begin
                  res_hdr.deliver_payload = 1'b1;
                  file_total_in           = tot_sat;
                  res_file_bytes          = tot_sat;
                  expected_seq_in         = expected_seq_ff + 16'd1;
               end
            end
         end
      end

      res_hdr.reply_type     = rtype;
      res_hdr.reply_seq      = rseq;
      res_hdr.reply_checksum = ~swr_pkg::fold_add({12'h000, rtype}, rseq);
      res_hdr.link_state     = link_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff  <= swr_pkg::MAX_PAYLOAD_RESET;
         expected_seq_ff <= 16'd0;
         link_ff         <= swr_pkg::LINK_IDLE;
         word_count_ff   <= 16'd0;
         pkt_type_ff     <= 16'd0;
         pkt_length_ff   <= 16'd0;
         pkt_seq_ff      <= 16'd0;
         running_sum_ff  <= 16'd0;
         file_total_ff   <= '0;
      end else begin
         max_payload_ff  <= max_payload_in;
         expected_seq_ff <= expected_seq_in;
         link_ff         <= link_in;
         word_count_ff   <= word_count_in;
         pkt_type_ff     <= pkt_type_in;
         pkt_length_ff   <= pkt_length_in;
         pkt_seq_ff      <= pkt_seq_in;
         running_sum_ff  <= running_sum_in;
         file_total_ff   <= file_total_in;
      end
   end

endmodule

[hdl/swr_out_stage.sv]
// Result register of the stop-and-wait receiver: holds one reply until it is taken.
// Depends on swr_pkg and swr_rsp_if.
module swr_out_stage #(
   parameter int FILE_BYTES_WIDTH = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        res_valid,
   input  swr_pkg::reply_hdr_type      res_hdr,
   input  logic [FILE_BYTES_WIDTH-1:0] res_file_bytes,
   output logic                        busy,
   swr_rsp_if.source                   rsp
);

   logic                        valid_ff, valid_in;
   swr_pkg::reply_hdr_type      hdr_ff, hdr_in;
   logic [FILE_BYTES_WIDTH-1:0] fbytes_ff, fbytes_in;

   // A held reply that is not being taken this cycle blocks the stage ahead.
   assign busy = valid_ff && !rsp.ready;

   always_comb begin
      hdr_in    = hdr_ff;
      fbytes_in = fbytes_ff;
      valid_in  = busy;
      if (res_valid) begin
         hdr_in    = res_hdr;
         fbytes_in = res_file_bytes;
         valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      hdr_ff    <= hdr_in;
      fbytes_ff <= fbytes_in;
   end

   assign rsp.valid           = valid_ff;
   assign rsp.reply_type      = hdr_ff.reply_type;
   assign rsp.reply_seq       = hdr_ff.reply_seq;
   assign rsp.reply_checksum  = hdr_ff.reply_checksum;
   assign rsp.accepted        = hdr_ff.accepted;
   assign rsp.deliver_payload = hdr_ff.deliver_payload;
   assign rsp.payload_bytes   = hdr_ff.payload_bytes;
   assign rsp.file_done       = hdr_ff.file_done;
   assign rsp.file_bytes      = fbytes_ff;
   assign rsp.link_state      = hdr_ff.link_state;

endmodule

[verif/stop_and_wait_receiver_tb.sv]
// Self-checking testbench for the stop-and-wait receiver: datagram words in, reply headers out.
// Needs swr_pkg, the swr_*_if interfaces and the stop_and_wait_receiver RTL.
`timescale 1ns / 100ps

package swr_tb_pkg;
   import swr_pkg::*;

   // The narrowest file counter width the receiver supports.
   localparam int FILE_TOTAL_WIDTH = 16;
   localparam longint unsigned TOTAL_CAP = (64'd1 << FILE_TOTAL_WIDTH) - 64'd1;
   localparam int unsigned MAX_PRINTED = 200;

   typedef logic [15:0] word_queue[$];

   typedef enum int {
      GAP_NONE,
      GAP_SPARSE,
      GAP_FULL
   } gap_kind;

   typedef struct {
      reply_code_type              kind;
      logic [15:0]                 seq;
      logic [15:0]                 cks;
      logic                        accepted;
      logic                        deliver;
      logic [15:0]                 bytes;
      logic                        done;
      logic [FILE_TOTAL_WIDTH-1:0] total;
      link_type                    link;
   } reply_fields;

   function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   function automatic int unsigned draw_gap(gap_kind mode);
      case (mode)
         GAP_NONE: return 0;
         GAP_FULL: return $urandom_range(0, 15);
         default:  return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      endcase
   endfunction

   class reply_scoreboard;
      reply_fields replies_due[$];
      int unsigned errors = 0;
      int unsigned replies_seen = 0;

      logic [15:0]                 payload_limit = MAX_PAYLOAD_RESET;
      logic [15:0]                 next_seq = '0;
      logic [15:0]                 word_count = '0;
      logic [15:0]                 pkt_type = '0;
      logic [15:0]                 pkt_length = '0;
      logic [15:0]                 pkt_seq = '0;
      logic [15:0]                 running_sum = '0;
      link_type                    link = LINK_IDLE;
      logic [FILE_TOTAL_WIDTH-1:0] file_total = '0;

      task report(string msg);
         errors++;
         if (errors <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
      endtask

      // Advances the receiver state by one accepted word and queues the reply it causes.
      function void take_word(logic [15:0] w, logic last);
         int unsigned idx;
         int unsigned need;
         longint unsigned sum_total;
         bit good;
         reply_fields r;
         if (link == LINK_CLOSED) return;
         idx = 32'(word_count);
         if (idx == 0) begin
            pkt_type = w;
            pkt_length = '0;
            pkt_seq = '0;
            running_sum = '0;
         end
         if (idx == 1) pkt_length = w;
         if (idx == 3) pkt_seq = w;
         need = 32'(HEADER_WORDS) + ((32'(pkt_length) + 1) >> 1);
         if (idx < 32'(HEADER_WORDS)) begin
            running_sum = ones_add(running_sum, w);
         end else if (idx < need) begin
            if (pkt_length[0] && idx == need - 1)
               running_sum = ones_add(running_sum, {8'h00, w[7:0]});
            else
               running_sum = ones_add(running_sum, w);
         end
         if (word_count != WORD_COUNT_MAX) word_count++;
         if (!last) return;

         good = word_count >= HEADER_WORDS && 32'(word_count) >= need &&
                pkt_length <= payload_limit && running_sum == SUM_GOOD &&
                pkt_seq == next_seq;
         word_count = '0;
         r.accepted = good;
         r.deliver = 1'b0;
         r.done = 1'b0;
         r.bytes = pkt_length;
         r.total = file_total;
         if (good) begin
            r.seq = next_seq;
            if (link == LINK_IDLE && pkt_type == PKT_SYN) begin
               r.kind = REPLY_SYN_ACK;
               link = LINK_OPEN;
            end else if (pkt_type == PKT_FIN) begin
               r.kind = REPLY_FIN_ACK;
               link = LINK_CLOSED;
            end else if (pkt_type == PKT_END) begin
               r.kind = REPLY_END_ACK;
            end else begin
               r.kind = REPLY_ACK;
            end
            if (r.kind == REPLY_END_ACK) begin
               r.done = 1'b1;
               file_total = '0;
            end else if (r.kind != REPLY_FIN_ACK) begin
               r.deliver = 1'b1;
               sum_total = 64'(file_total) + 64'(pkt_length);
               if (sum_total > TOTAL_CAP) sum_total = TOTAL_CAP;
               file_total = sum_total[FILE_TOTAL_WIDTH-1:0];
               r.total = file_total;
               next_seq++;
            end
         end else begin
            r.seq = next_seq - 16'd1;
            if (link == LINK_IDLE && pkt_type == PKT_SYN) r.kind = REPLY_SYN_ACK;
            else r.kind = REPLY_ACK;
         end
         r.cks = ~ones_add({12'h000, r.kind}, r.seq);
         r.link = link;
         replies_due.push_back(r);
      endfunction

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("reply %0d: %s is 0x%0h, expected 0x%0h",
                             replies_seen, name, got, want));
      endtask

      task check_reply(reply_fields got);
         reply_fields want;
         replies_seen++;
         if (replies_due.size() == 0) begin
            report($sformatf("reply %0d arrived with no datagram outstanding", replies_seen));
            return;
         end
         want = replies_due.pop_front();
         check_field("reply_type", 32'(got.kind), 32'(want.kind));
         check_field("reply_seq", 32'(got.seq), 32'(want.seq));
         check_field("reply_checksum", 32'(got.cks), 32'(want.cks));
         check_field("accepted", 32'(got.accepted), 32'(want.accepted));
         check_field("deliver_payload", 32'(got.deliver), 32'(want.deliver));
         check_field("payload_bytes", 32'(got.bytes), 32'(want.bytes));
         check_field("file_done", 32'(got.done), 32'(want.done));
         check_field("file_bytes", 32'(got.total), 32'(want.total));
         check_field("link_state", 32'(got.link), 32'(want.link));
      endtask
   endclass
endpackage

module stop_and_wait_receiver_tb;
   import swr_pkg::*;
   import swr_tb_pkg::*;

   localparam int HALF_PERIOD = 10;
   localparam int RESET_CYCLES = 10;
   // Quiet time after the last reply before the payload limit is written.
   localparam int DRAIN_CYCLES = 4;
   localparam int TAIL_CYCLES = 10;
   // Cycles without any handshake before the run is declared hung. The slowest
   // legal stretch without a handshake is a sender gap plus a reply stall plus the pipeline.
   localparam int STALL_LIMIT = 2000;
   localparam int unsigned RANDOM_WORDS = 1000;
   localparam int PHASES = 10;

   logic clock;
   logic reset;

   swr_req_if req_bus();
   swr_rsp_if #(.FILE_BYTES_WIDTH(FILE_TOTAL_WIDTH)) rsp_bus();
   swr_csr_if csr_bus();

   stop_and_wait_receiver #(.FILE_BYTES_WIDTH(FILE_TOTAL_WIDTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   reply_scoreboard sb = new();

   gap_kind     sender_mode = GAP_FULL;
   gap_kind     receiver_mode = GAP_FULL;
   int unsigned words_sent = 0;
   int unsigned idle_cycles = 0;

   always begin
      clock = 1'b0;
      #(HALF_PERIOD);
      clock = 1'b1;
      #(HALF_PERIOD);
   end

   // Watchdog: any accepted request, reply or register write counts as progress.
   // Everything is sampled at the rising edge, before the block updates its outputs.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("stop_and_wait_receiver test failed");
         $finish;
      end
   end

   // All the driving tasks start and end just after a falling edge. A request is
   // presented after a random gap and held until the rising edge where ready is high;
   // when the next gap is zero, valid simply stays high with the new word.
   task automatic send_word(logic [15:0] w, logic last);
      int unsigned gap;
      gap = draw_gap(sender_mode);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.word <= w;
      req_bus.last <= last;
      do @(posedge clock); while (!req_bus.ready);
      sb.take_word(w, last);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_datagram(word_queue q);
      foreach (q[i]) send_word(q[i], i == q.size() - 1);
   endtask

   // Builds a datagram whose checksum field makes the ones'-complement sum come out
   // as all ones, then optionally spoils it. The high byte of an odd final payload
   // word carries random junk that the receiver has to mask off. A nonzero keep
   // cuts the datagram to that many words; extra words trail the counted bytes.
   task automatic send_built(logic [15:0] kind, logic [15:0] len, logic [15:0] seq,
                             int unsigned extra, bit flip_sum, int unsigned keep);
      word_queue q;
      int unsigned n;
      logic [15:0] sum;
      logic [15:0] v;
      n = (32'(len) + 1) / 2;
      q.push_back(kind);
      q.push_back(len);
      q.push_back(16'h0000);
      q.push_back(seq);
      repeat (n) q.push_back(16'($urandom));
      sum = '0;
      foreach (q[i]) begin
         v = q[i];
         if (len[0] && i == 3 + n) v[15:8] = 8'h00;
         sum = ones_add(sum, v);
      end
      q[2] = ~sum;
      // A single flipped bit can never land on the other representation of zero.
      if (flip_sum) q[2] = q[2] ^ (16'h0001 << $urandom_range(0, 15));
      repeat (extra) q.push_back(16'($urandom));
      if (keep != 0) begin
         while (q.size() > keep) void'(q.pop_back());
      end
      send_datagram(q);
   endtask

   // Waits, with the request side quiet, until every reply that is due has arrived.
   task automatic wait_replies_drained();
      req_bus.valid <= 1'b0;
      while (sb.replies_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_payload_limit(logic [15:0] value);
      wait_replies_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.max_payload_bytes <= value;
      do @(posedge clock); while (!csr_bus.ready);
      sb.payload_limit = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // A packet type for the random part. An accepted FIN would close the link for
   // good, so FIN only shows up where the datagram is certain to be rejected.
   function automatic logic [15:0] pick_kind(bit allow_fin);
      int unsigned r;
      logic [15:0] k;
      r = $urandom_range(0, 19);
      if (r < 2) return PKT_SYN;
      if (r < 4) return PKT_END;
      if (r == 4) return allow_fin ? PKT_FIN : 16'd2;
      if (r < 9) k = 16'($urandom);
      else k = 16'($urandom_range(0, 8));
      if (k == PKT_FIN && !allow_fin) k = 16'd2;
      return k;
   endfunction

   // One datagram of the random part: mostly well formed with random content, the
   // rest spoiled checksums, wrong sequence numbers, oversized and short datagrams,
   // and plain noise.
   task automatic random_datagram();
      int unsigned pick;
      int unsigned len_cap;
      int unsigned extra;
      int unsigned need;
      int unsigned keep;
      logic [15:0] limit;
      logic [15:0] len;
      word_queue q;
      if ($urandom_range(0, 5) == 0) sender_mode = gap_kind'($urandom_range(0, 2));
      limit = sb.payload_limit;
      len_cap = (limit < 12) ? limit : 12;
      if ($urandom_range(0, 9) == 0) len_cap = (limit < 40) ? limit : 40;
      len = 16'($urandom_range(0, len_cap));
      extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         send_built(pick_kind(1'b0), len, sb.next_seq, extra, 1'b0, 0);
      end else if (pick < 70) begin
         send_built(pick_kind(1'b1), len, sb.next_seq, extra, 1'b1, 0);
      end else if (pick < 78) begin
         send_built(pick_kind(1'b1), len, sb.next_seq ^ (16'h0001 << $urandom_range(0, 15)),
                    extra, 1'b0, 0);
      end else if (pick < 86 && limit <= 64) begin
         // Oversized but complete, so only the length check can reject it.
         send_built(pick_kind(1'b1), limit + 16'($urandom_range(1, 8)), sb.next_seq,
                    extra, 1'b0, 0);
      end else if (pick < 86 && limit != 16'hffff) begin
         // Large length fields are sent cut short to keep the run brief.
         send_built(pick_kind(1'b1), 16'($urandom_range(32'(limit) + 1, 65535)), sb.next_seq,
                    0, 1'b0, $urandom_range(4, 12));
      end else if (pick < 94) begin
         need = 4 + (32'(len) + 1) / 2;
         if (need > 4 && $urandom_range(0, 1) == 1) keep = $urandom_range(4, need - 1);
         else keep = $urandom_range(1, 3);
         send_built(pick_kind(1'b1), len, sb.next_seq, 0, 1'b0, keep);
      end else begin
         repeat ($urandom_range(1, 10)) q.push_back(16'($urandom));
         if (q[0] == PKT_FIN) q[0] = PKT_END;
         send_datagram(q);
      end
   endtask

   // Reply side: a random stall before each reply, with stretches of no stalls at all.
   initial begin : reply_sink
      int unsigned gap;
      reply_fields got;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 7) == 0) receiver_mode = gap_kind'($urandom_range(0, 2));
         gap = draw_gap(receiver_mode);
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.kind = reply_code_type'(rsp_bus.reply_type);
         got.seq = rsp_bus.reply_seq;
         got.cks = rsp_bus.reply_checksum;
         got.accepted = rsp_bus.accepted;
         got.deliver = rsp_bus.deliver_payload;
         got.bytes = rsp_bus.payload_bytes;
         got.done = rsp_bus.file_done;
         got.total = rsp_bus.file_bytes;
         got.link = link_type'(rsp_bus.link_state);
         sb.check_reply(got);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [15:0] phase_limits [PHASES];
      int unsigned random_start;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.word = '0;
      req_bus.last = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.max_payload_bytes = '0;
      phase_limits = '{16'd3, 16'd0, 16'd65535, 16'd17, MAX_PAYLOAD_RESET, 16'd1, 16'd40,
                       16'd2, 16'd64, 16'($urandom_range(0, 500))};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, with the reset value of the payload limit and the link not
      // yet connected. A lone SYN word is too short and gets a rejecting SYN_ACK
      // that echoes the sequence number just below zero.
      send_built(PKT_SYN, 16'd0, 16'd0, 0, 1'b0, 1);
      // Data before any SYN is still accepted and advances the sequence.
      send_built(16'd2, 16'd0, sb.next_seq, 0, 1'b0, 0);
      // SYN with a spoiled checksum, then a good SYN with an odd payload connects.
      send_built(PKT_SYN, 16'd2, sb.next_seq, 0, 1'b1, 0);
      send_built(PKT_SYN, 16'd1, sb.next_seq, 0, 1'b0, 0);
      // Once connected a good SYN is answered with a plain ACK.
      send_built(PKT_SYN, 16'd0, sb.next_seq, 0, 1'b0, 0);
      // Odd length with words trailing past the counted bytes.
      send_built(16'd2, 16'd3, sb.next_seq, 2, 1'b0, 0);
      // Wrong sequence number, ahead of the expected one.
      send_built(16'd2, 16'd2, sb.next_seq + 16'd5, 0, 1'b0, 0);
      // Short datagrams: header cut off, then payload cut off.
      send_built(16'd2, 16'd6, sb.next_seq, 0, 1'b0, 3);
      send_built(16'd2, 16'd6, sb.next_seq, 0, 1'b0, 5);
      // All-ones type and length, cut short.
      send_built(16'hffff, 16'hffff, sb.next_seq, 0, 1'b0, 6);
      // END closes the file and clears the byte total.
      send_built(PKT_END, 16'd0, sb.next_seq, 0, 1'b0, 0);
      // A FIN with the wrong sequence number must not close the link.
      send_built(PKT_FIN, 16'd0, sb.next_seq + 16'd1, 0, 1'b0, 0);
      send_built(16'd0, 16'd0, sb.next_seq, 0, 1'b0, 0);

      // Zero payload limit: one byte is oversized, zero is fine.
      write_payload_limit(16'd0);
      send_built(16'd2, 16'd1, sb.next_seq, 0, 1'b0, 0);
      send_built(16'd3, 16'd0, sb.next_seq, 0, 1'b0, 0);

      // Random part in phases. Every phase change first lets all outstanding
      // replies come back with the request side paused, then moves the limit.
      random_start = words_sent;
      for (int p = 0; p < PHASES; p++) begin
         write_payload_limit(phase_limits[p]);
         while (words_sent < random_start + (p + 1) * RANDOM_WORDS / PHASES) random_datagram();
      end

      // A good FIN closes the link; everything after it is swallowed without a reply.
      wait_replies_drained();
      @(negedge clock);
      sender_mode = GAP_SPARSE;
      send_built(PKT_FIN, 16'd0, sb.next_seq, 0, 1'b0, 0);
      send_built(16'd2, 16'd2, sb.next_seq, 0, 1'b0, 0);
      send_built(PKT_SYN, 16'd0, sb.next_seq, 0, 1'b0, 0);

      wait_replies_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.errors == 0) begin
         $display("stop_and_wait_receiver test passed");
      end else begin
         $display("stop_and_wait_receiver test failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/swr_pkg.sv
hdl/swr_if.sv
hdl/swr_in_stage.sv
hdl/swr_core.sv
hdl/swr_out_stage.sv
hdl/stop_and_wait_receiver.sv
verif/stop_and_wait_receiver_tb.sv
